// ----- hw/rtl/owrb_pkg.sv -----
package owrb_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the request and result.
    localparam int FUNC_W      = 3;
    localparam int ID_W        = 8;
    localparam int IN_PAY_W    = 32;
    localparam int POS_W       = 8;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 1;

    // Request function codes.
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_GET   = 3'd2,
        OP_FIND  = 3'd3,
        OP_ERASE = 3'd4,
        OP_FLUSH = 3'd5
    } op_t;

    // Source of the store read address.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_OFFSET,
        RD_SCAN
    } rd_sel_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_start;
        logic    scan_step;
        logic    finish;
        logic    use_entry;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              count_zero;
        logic              get_in_range;
        logic              match;
        logic              scan_end;
        logic              out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/owrb_ctrl.sv -----
module owrb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  owrb_pkg::dp_status_t status,
    output owrb_pkg::dp_cmd_t    cmd
);

    owrb_pkg::ctrl_state_t state_reg;
    owrb_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= owrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            owrb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = owrb_pkg::ST_EXEC;
                end
            end
            owrb_pkg::ST_EXEC:
            begin
                if ((status.func == owrb_pkg::OP_POP) && !status.count_zero)
                begin
                    state_next = owrb_pkg::ST_READ;
                end
                else if ((status.func == owrb_pkg::OP_GET) && status.get_in_range)
                begin
                    state_next = owrb_pkg::ST_READ;
                end
                else if (status.func == owrb_pkg::OP_FIND)
                begin
                    state_next = owrb_pkg::ST_SCAN;
                end
                else if (status.out_free)
                begin
                    state_next = owrb_pkg::ST_IDLE;
                end
            end
            owrb_pkg::ST_READ:
            begin
                if (status.out_free)
                begin
                    state_next = owrb_pkg::ST_IDLE;
                end
            end
            owrb_pkg::ST_SCAN:
            begin
                if ((status.match || status.scan_end) && status.out_free)
                begin
                    state_next = owrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = owrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        cmd.rd_sel = owrb_pkg::RD_HEAD;
        unique case (state_reg)
            owrb_pkg::ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            owrb_pkg::ST_EXEC:
            begin
                unique case (status.func)
                    owrb_pkg::OP_POP:
                    begin
                        if (status.count_zero)
                        begin
                            cmd.finish = status.out_free;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = owrb_pkg::RD_HEAD;
                        end
                    end
                    owrb_pkg::OP_GET:
                    begin
                        if (status.get_in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = owrb_pkg::RD_OFFSET;
                        end
                        else
                        begin
                            cmd.finish = status.out_free;
                        end
                    end
                    owrb_pkg::OP_FIND:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    default:
                    begin
                        cmd.finish = status.out_free;
                    end
                endcase
            end
            owrb_pkg::ST_READ:
            begin
                cmd.finish    = status.out_free;
                cmd.use_entry = 1'b1;
            end
            owrb_pkg::ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.finish    = status.out_free;
                    cmd.use_entry = 1'b1;
                end
                else if (status.scan_end)
                begin
                    cmd.finish = status.out_free;
                end
                else
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = owrb_pkg::RD_SCAN;
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/owrb_dp.sv -----
module owrb_dp
#(
    parameter int DEPTH        = owrb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = owrb_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  owrb_pkg::dp_cmd_t                 cmd,
    output owrb_pkg::dp_status_t              status,
    input  logic [owrb_pkg::FUNC_W-1:0]       in_func,
    input  logic [owrb_pkg::ID_W-1:0]         in_id,
    input  logic [owrb_pkg::IN_PAY_W-1:0]     in_payload,
    input  logic [owrb_pkg::POS_W-1:0]        in_pos,
    input  logic                              m_tready,
    output logic                              out_valid,
    output logic                              out_entry_valid,
    output logic [owrb_pkg::ID_W-1:0]         out_id,
    output logic [owrb_pkg::IN_PAY_W-1:0]     out_payload,
    output logic                              out_erase_ok,
    output logic [owrb_pkg::COUNT_OUT_W-1:0]  out_count,
    output logic                              out_empty,
    output logic                              out_full
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = ((PTR_W > owrb_pkg::POS_W) ? PTR_W : owrb_pkg::POS_W) + 1;
    localparam int ENTRY_W = owrb_pkg::ID_W + PAYLOAD_BITS;

    // Entry store, no reset.
    logic [ENTRY_W-1:0] mem [DEPTH];

    // Request registers.
    logic [owrb_pkg::FUNC_W-1:0] req_func_reg;
    logic [owrb_pkg::ID_W-1:0]   req_id_reg;
    logic [PAYLOAD_BITS-1:0]     req_payload_reg;
    logic [owrb_pkg::POS_W-1:0]  req_pos_reg;

    // Ring state.
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Scan state.
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_valid_reg, chk_valid_next;

    // Read port.
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   rd_addr;

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    logic                             out_entry_valid_reg;
    logic [owrb_pkg::ID_W-1:0]        out_id_reg;
    logic [owrb_pkg::IN_PAY_W-1:0]    out_payload_reg;
    logic                             out_erase_ok_reg;
    logic [owrb_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic                             out_empty_reg;
    logic                             out_full_reg;

    logic [PAYLOAD_BITS+owrb_pkg::IN_PAY_W-1:0] in_pay_ext;
    logic [PAYLOAD_BITS+owrb_pkg::IN_PAY_W-1:0] rd_pay_ext;
    logic [CNT_W+owrb_pkg::COUNT_OUT_W-1:0]     count_out_ext;
    logic [SUM_W-1:0] pos_ext, cnt_ext, offset_sum;
    logic [PTR_W-1:0] offset_ptr, wp_inc, rp_inc, scan_inc;
    logic             erase_fit, count_full, out_free;
    logic [owrb_pkg::ID_W-1:0] rd_id;

    // Payload trim on entry and widen on exit.
    assign in_pay_ext = {{PAYLOAD_BITS{1'b0}}, in_payload};
    assign rd_pay_ext = {{owrb_pkg::IN_PAY_W{1'b0}}, rd_data_reg[PAYLOAD_BITS-1:0]};
    assign rd_id      = rd_data_reg[ENTRY_W-1:PAYLOAD_BITS];

    // Offset from the oldest entry; the sum stays below twice the depth whenever the offset is used.
    assign pos_ext    = SUM_W'(req_pos_reg);
    assign cnt_ext    = SUM_W'(count_reg);
    assign offset_sum = SUM_W'(rp_reg) + pos_ext;
    assign offset_ptr = (offset_sum >= SUM_W'(DEPTH)) ? PTR_W'(offset_sum - SUM_W'(DEPTH))
                                                      : PTR_W'(offset_sum);
    assign erase_fit  = (pos_ext <= cnt_ext);
    assign count_full = (count_reg == CNT_W'(DEPTH));

    // Wrapping increments.
    assign wp_inc   = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign scan_inc = (scan_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;

    assign out_free = !out_valid_reg || m_tready;

    // Status to the controller.
    always_comb
    begin
        status.func         = req_func_reg;
        status.count_zero   = (count_reg == '0);
        status.get_in_range = (pos_ext < cnt_ext);
        status.match        = chk_valid_reg && (rd_id == req_id_reg);
        status.scan_end     = (scan_idx_reg == count_reg);
        status.out_free     = out_free;
    end

    // Read address select.
    always_comb
    begin
        unique case (cmd.rd_sel)
            owrb_pkg::RD_HEAD:   rd_addr = rp_reg;
            owrb_pkg::RD_OFFSET: rd_addr = offset_ptr;
            owrb_pkg::RD_SCAN:   rd_addr = scan_ptr_reg;
            default:             rd_addr = rp_reg;
        endcase
    end

    // Ring state update when a request completes.
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (cmd.finish)
        begin
            unique case (req_func_reg)
                owrb_pkg::OP_PUSH:
                begin
                    wp_next = wp_inc;
                    if (count_full)
                    begin
                        rp_next = rp_inc;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                owrb_pkg::OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        rp_next    = rp_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                owrb_pkg::OP_ERASE:
                begin
                    if (erase_fit)
                    begin
                        rp_next    = offset_ptr;
                        count_next = CNT_W'(cnt_ext - pos_ext);
                    end
                end
                owrb_pkg::OP_FLUSH:
                begin
                    wp_next    = '0;
                    rp_next    = '0;
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Scan progress.
    always_comb
    begin
        scan_ptr_next  = scan_ptr_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        if (cmd.scan_start)
        begin
            scan_ptr_next  = rp_reg;
            scan_idx_next  = '0;
            chk_valid_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_next  = scan_inc;
            scan_idx_next  = scan_idx_reg + 1'b1;
            chk_valid_next = 1'b1;
        end
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && !m_tready);
    assign count_out_ext  = {{owrb_pkg::COUNT_OUT_W{1'b0}}, count_next};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_func_reg    <= in_func;
            req_id_reg      <= in_id;
            req_payload_reg <= in_pay_ext[PAYLOAD_BITS-1:0];
            req_pos_reg     <= in_pos;
        end
    end

    // Store write on push and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && (req_func_reg == owrb_pkg::OP_PUSH))
        begin
            mem[wp_reg] <= {req_id_reg, req_payload_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_entry_valid_reg <= cmd.use_entry;
            out_id_reg          <= cmd.use_entry ? rd_id : '0;
            out_payload_reg     <= cmd.use_entry ? rd_pay_ext[owrb_pkg::IN_PAY_W-1:0] : '0;
            out_erase_ok_reg    <= (req_func_reg == owrb_pkg::OP_ERASE) && erase_fit;
            out_count_reg       <= count_out_ext[owrb_pkg::COUNT_OUT_W-1:0];
            out_empty_reg       <= (count_next == '0);
            out_full_reg        <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_entry_valid = out_entry_valid_reg;
    assign out_id          = out_id_reg;
    assign out_payload     = out_payload_reg;
    assign out_erase_ok    = out_erase_ok_reg;
    assign out_count       = out_count_reg;
    assign out_empty       = out_empty_reg;
    assign out_full        = out_full_reg;

    // The stored count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Pointers stay inside the store.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_W'(DEPTH - 1)) && (rp_reg <= PTR_W'(DEPTH - 1)))
        else $error("ring pointer out of range");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // The scan never reads past the stored entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (scan_idx_reg < count_reg))
        else $error("scan beyond stored entries");

endmodule

// ----- hw/rtl/overwrite_ring_buffer_with_id_search_top.sv -----
// Push, erase, flush and unused codes go from idle to the execute state, which loads the
// result; pop and get that return an entry add the read state behind a registered store read.
// Find reads one stored entry per cycle, from the oldest, until an id matches or none are left.
// One request is in work at a time; a new one is taken while the previous result waits.
// Reset clears the pointers, the count and the result valid; the store is not cleared.
module overwrite_ring_buffer_with_id_search_top
#(
    parameter int DEPTH        = owrb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = owrb_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: entry_id[8], entry_payload[32], position[8].
    input  logic [owrb_pkg::S_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0: func[3].
    input  logic [owrb_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: out_id[8], out_payload[32], erase_ok[1], entry_count[5],
    // is_empty[1], is_full[1].
    output logic [owrb_pkg::M_TDATA_W-1:0]     m_tdata,
    // Fields from bit 0: entry_valid[1].
    output logic [owrb_pkg::M_TUSER_W-1:0]     m_tuser
);

    owrb_pkg::dp_cmd_t    cmd;
    owrb_pkg::dp_status_t status;

    logic                             out_entry_valid;
    logic [owrb_pkg::ID_W-1:0]        out_id;
    logic [owrb_pkg::IN_PAY_W-1:0]    out_payload;
    logic                             out_erase_ok;
    logic [owrb_pkg::COUNT_OUT_W-1:0] out_count;
    logic                             out_empty;
    logic                             out_full;

    // Sequencing of each request.
    owrb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, ring pointers and result register.
    owrb_dp
    #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_func         (s_tuser),
        .in_id           (s_tdata[7:0]),
        .in_payload      (s_tdata[39:8]),
        .in_pos          (s_tdata[47:40]),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_entry_valid (out_entry_valid),
        .out_id          (out_id),
        .out_payload     (out_payload),
        .out_erase_ok    (out_erase_ok),
        .out_count       (out_count),
        .out_empty       (out_empty),
        .out_full        (out_full)
    );

    // Result packing.
    assign m_tdata = {out_full, out_empty, out_count, out_erase_ok, out_payload, out_id};
    assign m_tuser = out_entry_valid;

endmodule

// ----- tb/overwrite_ring_buffer_with_id_search_checker.sv -----
module overwrite_ring_buffer_with_id_search_checker
#(
    parameter int DEPTH        = owrb_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = owrb_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // Fields from bit 0: entry_id[8], entry_payload[32], position[8].
    input  logic [owrb_pkg::S_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0: func[3].
    input  logic [owrb_pkg::FUNC_W-1:0]        s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: out_id[8], out_payload[32], erase_ok[1], entry_count[5],
    // is_empty[1], is_full[1].
    input  logic [owrb_pkg::M_TDATA_W-1:0]     m_tdata,
    // Fields from bit 0: entry_valid[1].
    input  logic [owrb_pkg::M_TUSER_W-1:0]     m_tuser,
    output int                                 error_count,
    output int                                 pending_results,
    output int                                 checked_results
);

    import owrb_pkg::*;

    // One status record as the block reports it for each request.
    typedef struct packed {
        logic        entry_valid;
        logic [7:0]  out_id;
        logic [31:0] out_payload;
        logic        erase_ok;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic        is_full;
    } ring_status_t;

    localparam logic [63:0] PAYLOAD_MASK = (64'd1 << PAYLOAD_BITS) - 64'd1;

    // Shadow copy of the ring contents and pointers.
    logic [7:0]   shadow_id [DEPTH];
    logic [31:0]  shadow_payload [DEPTH];
    int           head_ptr;
    int           tail_ptr;
    int           stored;
    ring_status_t status_queue [$];

    // Apply one request to the shadow ring and return the status it should give.
    function automatic ring_status_t apply_ring_request(input logic [FUNC_W-1:0] code,
                                                        input logic [7:0] id,
                                                        input logic [31:0] payload,
                                                        input logic [7:0] pos);
        ring_status_t res;
        int           slot;
        logic         hit;
        res = '0;
        hit = 1'b0;
        case (code)
            OP_PUSH:
            begin
                shadow_id[head_ptr]      = id;
                shadow_payload[head_ptr] = 32'(64'(payload) & PAYLOAD_MASK);
                head_ptr = (head_ptr + 1) % DEPTH;
                if (stored < DEPTH)
                    stored++;
                else
                    tail_ptr = (tail_ptr + 1) % DEPTH;
            end
            OP_POP:
            begin
                if (stored > 0)
                begin
                    res.entry_valid = 1'b1;
                    res.out_id      = shadow_id[tail_ptr];
                    res.out_payload = shadow_payload[tail_ptr];
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                    stored--;
                end
            end
            OP_GET:
            begin
                if (int'(pos) < stored)
                begin
                    slot = (tail_ptr + int'(pos)) % DEPTH;
                    res.entry_valid = 1'b1;
                    res.out_id      = shadow_id[slot];
                    res.out_payload = shadow_payload[slot];
                end
            end
            OP_FIND:
            begin
                // Oldest to newest; the first id match wins.
                for (int i = 0; i < stored; i++)
                begin
                    slot = (tail_ptr + i) % DEPTH;
                    if (!hit && shadow_id[slot] == id)
                    begin
                        hit = 1'b1;
                        res.entry_valid = 1'b1;
                        res.out_id      = shadow_id[slot];
                        res.out_payload = shadow_payload[slot];
                    end
                end
            end
            OP_ERASE:
            begin
                if (stored >= int'(pos))
                begin
                    tail_ptr = (tail_ptr + int'(pos)) % DEPTH;
                    stored  -= int'(pos);
                    res.erase_ok = 1'b1;
                end
            end
            OP_FLUSH:
            begin
                stored   = 0;
                head_ptr = 0;
                tail_ptr = 0;
            end
            default:
            begin
                // Spare codes only report the status.
            end
        endcase
        res.entry_count = stored[4:0];
        res.is_empty    = (stored == 0);
        res.is_full     = (stored == DEPTH);
        return res;
    endfunction

    // Report one field that differs from its prediction.
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Predict on each accepted request and check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        ring_status_t want;
        ring_status_t got;
        if (!rst_n)
        begin
            head_ptr        = 0;
            tail_ptr        = 0;
            stored          = 0;
            status_queue.delete();
            error_count     = 0;
            checked_results = 0;
            pending_results = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                status_queue.push_back(apply_ring_request(s_tuser, s_tdata[7:0],
                                                          s_tdata[39:8], s_tdata[47:40]));
            if (m_tvalid && m_tready)
            begin
                got.entry_valid = m_tuser[0];
                got.out_id      = m_tdata[7:0];
                got.out_payload = m_tdata[39:8];
                got.erase_ok    = m_tdata[40];
                got.entry_count = m_tdata[45:41];
                got.is_empty    = m_tdata[46];
                got.is_full     = m_tdata[47];
                if (status_queue.size() == 0)
                begin
                    $display("%0t: result with no request waiting: expected none, actual %h",
                             $time, got);
                    error_count++;
                end
                else
                begin
                    want = status_queue.pop_front();
                    compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
                    compare_field("out_id",      32'(want.out_id),      32'(got.out_id));
                    compare_field("out_payload", want.out_payload,      got.out_payload);
                    compare_field("erase_ok",    32'(want.erase_ok),    32'(got.erase_ok));
                    compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    compare_field("is_empty",    32'(want.is_empty),    32'(got.is_empty));
                    compare_field("is_full",     32'(want.is_full),     32'(got.is_full));
                    checked_results++;
                end
            end
            pending_results = status_queue.size();
        end
    end

endmodule

// ----- tb/overwrite_ring_buffer_with_id_search_top_test.sv -----
module overwrite_ring_buffer_with_id_search_top_test;

    import owrb_pkg::*;

    localparam int               RANDOM_REQUESTS = 600;
    localparam int               QUIET_TAIL      = 100;
    localparam int               CYCLE_LIMIT     = 200000;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A   = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B   = 3'd7;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [FUNC_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    int                      error_count;
    int                      pending_results;
    int                      checked_results;
    int                      cycle_count;
    int                      sent_requests;
    int                      tx_idle_pct;
    int                      rx_idle_pct;
    logic                    quiet;

    overwrite_ring_buffer_with_id_search_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    overwrite_ring_buffer_with_id_search_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results);
            $display("** overwrite_ring_buffer_with_id_search_top: FAILED **");
            $finish;
        end
    end

    // Offer one request, with an occasional idle burst ahead of it, and wait until taken.
    task automatic send_request(input logic [FUNC_W-1:0] code, input logic [7:0] id,
                                input logic [31:0] payload, input logic [7:0] pos);
        int gap;
        @(negedge clk);
        if (!quiet && tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = code;
        s_tdata  = {pos, payload, id};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent_requests++;
    endtask

    // Result side: stall in bursts, with changing intensity and quiet stretches.
    initial
    begin
        int ticks;
        m_tready    = 1'b0;
        rx_idle_pct = 0;
        ticks       = 0;
        forever
        begin
            @(negedge clk);
            ticks++;
            if (ticks % 64 == 0)
                rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (!quiet && rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Request stream and verdict.
    initial
    begin
        int          r;
        logic [7:0]  id;
        logic [7:0]  pos;
        logic [31:0] payload;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_PUSH;
        quiet         = 1'b0;
        tx_idle_pct   = 20;
        sent_requests = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Requests on an empty ring and the spare codes.
        send_request(OP_POP,   8'h00, 32'h0, 8'd0);
        send_request(OP_GET,   8'h00, 32'h0, 8'd0);
        send_request(OP_FIND,  8'h00, 32'h0, 8'd0);
        send_request(OP_ERASE, 8'h00, 32'h0, 8'd0);
        send_request(OP_ERASE, 8'h00, 32'h0, 8'd1);
        send_request(FUNC_SPARE_A, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(FUNC_SPARE_B, 8'hA5, 32'h1234_5678, 8'h5A);

        // Fill past full so the oldest entry gets overwritten.
        for (int i = 0; i < 17; i++)
        begin
            id      = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(8'h10 + i);
            payload = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
            send_request(OP_PUSH, id, payload, 8'd0);
        end
        send_request(OP_FIND,  8'h00, 32'h0, 8'd0);
        send_request(OP_FIND,  8'hFF, 32'h0, 8'd0);
        send_request(OP_GET,   8'h00, 32'h0, 8'd15);
        send_request(OP_ERASE, 8'h00, 32'h0, 8'd255);
        send_request(OP_POP,   8'h00, 32'h0, 8'd0);
        send_request(OP_FLUSH, 8'h00, 32'h0, 8'd0);

        // Random mix that favors pushes so the ring often runs full and wraps.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
                tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            if (n == RANDOM_REQUESTS - QUIET_TAIL)
                quiet = 1'b1;
            id      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            payload = $urandom;
            r       = $urandom_range(0, 99);
            if (r < 8)
                pos = 8'($urandom);
            else if (r < 50)
                pos = 8'($urandom_range(0, 17));
            else
                pos = 8'($urandom_range(0, 4));
            r = $urandom_range(0, 99);
            if (r >= 38 && r < 50)
                send_request(OP_POP, id, payload, pos);
            else if (r >= 50 && r < 65)
                send_request(OP_GET, id, payload, pos);
            else if (r >= 65 && r < 83)
                send_request(OP_FIND, id, payload, pos);
            else if (r >= 83 && r < 93)
                send_request(OP_ERASE, id, payload, pos);
            else if (r >= 93 && r < 95)
                send_request(OP_FLUSH, id, payload, pos);
            else if (r == 95)
                send_request(FUNC_SPARE_A, id, payload, pos);
            else if (r == 96)
                send_request(FUNC_SPARE_B, id, payload, pos);
            else
                send_request(OP_PUSH, id, payload, pos);
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        // Drain the remaining results, then allow for the longest search.
        while (pending_results != 0)
            @(posedge clk);
        repeat (DEPTH_DEF + 8) @(posedge clk);

        $display("Sent %0d requests covering push, pop, get, find, erase, flush and spare codes,",
                 sent_requests);
        $display("including overwrite on full, wrap-around and failed lookups; %0d results checked.",
                 checked_results);
        if (error_count == 0)
            $display("** overwrite_ring_buffer_with_id_search_top: PASSED **");
        else
            $display("** overwrite_ring_buffer_with_id_search_top: FAILED **");
        $finish;
    end

endmodule
